FILE: rtl/dbs_pkg.sv
`default_nettype none
package dbs_pkg;

    localparam int DEPTH_W    = 32;
    localparam int HANDLE_W   = 16;
    localparam int VCNT_W     = 5;
    localparam int SUM_W      = 32;
    localparam int BSIZE_W    = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam int NUM_BUCKETS_DEF = 64;
    localparam int POOL_SIZE_DEF   = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_CACHE_EN    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_SIZE = 1'b1;

    localparam logic               CACHE_EN_RST    = 1'b1;
    localparam logic [BSIZE_W-1:0] BUCKET_SIZE_RST = 32'h0001_0000;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_FLUSH  = 1'b1;

    localparam logic [DEPTH_W-1:0] DEPTH_SAT = '1;

    // control shared by every cell of the sorted chain
    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctl;

endpackage
`default_nettype wire

FILE: rtl/dbs_div.sv
`default_nettype none
module dbs_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [dbs_pkg::DEPTH_W-1:0] i_rem,
    input  wire logic [dbs_pkg::DEPTH_W-1:0] i_dvd,
    input  wire logic [dbs_pkg::DEPTH_W-1:0] i_dsr,
    output logic                            o_done,
    output logic [dbs_pkg::DEPTH_W-1:0]     o_quo
);
    import dbs_pkg::*;

    localparam int CNT_W = $clog2(DEPTH_W);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [DEPTH_W-1:0] r_rem, n_rem;
    logic [DEPTH_W-1:0] r_quo, n_quo;
    logic [DEPTH_W-1:0] r_dsr, n_dsr;
    logic [DEPTH_W:0]   w_trial;
    logic [DEPTH_W+1:0] w_diff;
    logic               w_ge;

    // restoring division, one quotient bit per cycle
    assign w_trial = {r_rem, r_quo[DEPTH_W-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_dsr};
    assign w_ge    = ~w_diff[DEPTH_W+1];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = i_rem;
            n_quo  = i_dvd;
            n_dsr  = i_dsr;
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[DEPTH_W-1:0] : w_trial[DEPTH_W-1:0];
            n_quo = {r_quo[DEPTH_W-2:0], w_ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DEPTH_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dsr <= n_dsr;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule
`default_nettype wire

FILE: rtl/dbs_cell.sv
`default_nettype none
module dbs_cell #(
    parameter int KEY_W = 38
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire dbs_pkg::t_cell_ctl          i_ctl,
    input  wire logic [KEY_W-1:0]            i_new_key,
    input  wire logic [dbs_pkg::HANDLE_W-1:0] i_new_handle,
    input  wire logic                        i_prev_gt,
    input  wire logic                        i_prev_valid,
    input  wire logic [KEY_W-1:0]            i_prev_key,
    input  wire logic [dbs_pkg::HANDLE_W-1:0] i_prev_handle,
    input  wire logic                        i_next_valid,
    input  wire logic [KEY_W-1:0]            i_next_key,
    input  wire logic [dbs_pkg::HANDLE_W-1:0] i_next_handle,
    output logic                             o_gt,
    output logic                             o_valid,
    output logic [KEY_W-1:0]                 o_key,
    output logic [dbs_pkg::HANDLE_W-1:0]     o_handle
);
    import dbs_pkg::*;

    logic                r_valid, n_valid;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [HANDLE_W-1:0] r_handle, n_handle;
    logic                w_gt;

    // strictly farther entries stay ahead, so equal keys put the newest first
    assign w_gt = r_valid && (r_key > i_new_key);

    always_comb begin
        n_valid  = r_valid;
        n_key    = r_key;
        n_handle = r_handle;
        if (i_ctl.shift) begin
            n_valid  = i_next_valid;
            n_key    = i_next_key;
            n_handle = i_next_handle;
        end else if (i_ctl.insert && !w_gt) begin
            if (i_prev_gt) begin
                n_valid  = 1'b1;
                n_key    = i_new_key;
                n_handle = i_new_handle;
            end else begin
                n_valid  = i_prev_valid;
                n_key    = i_prev_key;
                n_handle = i_prev_handle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_handle <= n_handle;
    end

    assign o_gt     = w_gt;
    assign o_valid  = r_valid;
    assign o_key    = r_key;
    assign o_handle = r_handle;

endmodule
`default_nettype wire

FILE: rtl/depth_bucket_sorter.sv
// Back-to-front sorter for blended polygons. An insert (mode 0) of an opaque
// polygon, or any insert while cache_enable is 0, comes out in the next cycle
// as a pass-through with depth 0 and last set. Other inserts produce no
// result: depth = vertex_count / zinv_sum (Q16.16, saturating) and the bucket
// depth / bucket_size are found by a shared one-bit-per-cycle divider; the
// insert then drops into a chain of POOL_SIZE cells kept sorted on {bucket,
// depth}, farthest first, and no new item is taken before that is done.
// Inserts into a full pool are dropped. A flush (mode 1) pops one entry per
// cycle from the head of the chain while the output is not stalled, last set
// on the final one, and leaves the store empty.
`default_nettype none
module depth_bucket_sorter #(
    parameter int NUM_BUCKETS = dbs_pkg::NUM_BUCKETS_DEF,
    parameter int POOL_SIZE   = dbs_pkg::POOL_SIZE_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [dbs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [dbs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_mode,
    input  wire logic [dbs_pkg::HANDLE_W-1:0]   i_handle,
    input  wire logic [dbs_pkg::VCNT_W-1:0]     i_vertex_count,
    input  wire logic [dbs_pkg::SUM_W-1:0]      i_zinv_sum,
    input  wire logic                          i_blend_none,
    input  wire logic                          i_tex_alpha,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [dbs_pkg::HANDLE_W-1:0]        o_out_handle,
    output logic [dbs_pkg::DEPTH_W-1:0]         o_out_depth,
    output logic                               o_deferred,
    output logic                               o_last
);
    import dbs_pkg::*;

    localparam int BKT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int KEY_W = BKT_W + DEPTH_W;
    localparam int CNT_W = $clog2(POOL_SIZE + 1);
    localparam logic [BKT_W-1:0]   BKT_LAST   = BKT_W'(NUM_BUCKETS - 1);
    localparam logic [DEPTH_W-1:0] BKT_LAST_W = DEPTH_W'(NUM_BUCKETS - 1);
    localparam logic [CNT_W-1:0]   CNT_FULL   = CNT_W'(POOL_SIZE);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV1  = 3'd1;
    localparam logic [2:0] ST_DIV2  = 3'd2;
    localparam logic [2:0] ST_INS   = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;

    logic [2:0]          r_state, n_state;
    logic                r_cache_en;
    logic [BSIZE_W-1:0]  r_bsize;
    logic [CNT_W-1:0]    r_ecount, n_ecount;
    logic [HANDLE_W-1:0] r_handle, n_handle;
    logic [DEPTH_W-1:0]  r_depth, n_depth;
    logic [BKT_W-1:0]    r_bucket, n_bucket;

    logic                r_out_valid, n_out_valid;
    logic [HANDLE_W-1:0] r_out_handle, n_out_handle;
    logic [DEPTH_W-1:0]  r_out_depth, n_out_depth;
    logic                r_out_def, n_out_def;
    logic                r_out_last, n_out_last;

    logic                w_in_acc, w_out_free, w_pass;
    logic                div_start, div_done;
    logic [DEPTH_W-1:0]  div_rem, div_dvd, div_dsr, div_quo;
    t_cell_ctl           w_ctl;

    logic                c_gt    [POOL_SIZE];
    logic                c_valid [POOL_SIZE];
    logic [KEY_W-1:0]    c_key   [POOL_SIZE];
    logic [HANDLE_W-1:0] c_handle[POOL_SIZE];

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && w_out_free;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_pass     = (i_blend_none && !i_tex_alpha) || !r_cache_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache_en <= CACHE_EN_RST;
            r_bsize    <= BUCKET_SIZE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CACHE_EN:    r_cache_en <= i_cfg_data[0];
                CFG_BUCKET_SIZE: r_bsize    <= i_cfg_data[BSIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state      = r_state;
        n_ecount     = r_ecount;
        n_handle     = r_handle;
        n_depth      = r_depth;
        n_bucket     = r_bucket;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_handle = r_out_handle;
        n_out_depth  = r_out_depth;
        n_out_def    = r_out_def;
        n_out_last   = r_out_last;
        div_start    = 1'b0;
        div_rem      = '0;
        div_dvd      = '0;
        div_dsr      = r_bsize;
        w_ctl        = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_mode == MODE_FLUSH) begin
                        if (r_ecount != '0) n_state = ST_FLUSH;
                    end else if (w_pass) begin
                        n_out_valid  = 1'b1;
                        n_out_handle = i_handle;
                        n_out_depth  = '0;
                        n_out_def    = 1'b0;
                        n_out_last   = 1'b1;
                    end else if (r_ecount != CNT_FULL) begin
                        n_handle = i_handle;
                        if ((i_zinv_sum == '0) ||
                            ({15'd0, i_vertex_count, 12'd0} >= i_zinv_sum)) begin
                            n_depth = DEPTH_SAT;
                            if (r_bsize == '0) begin
                                n_bucket = BKT_LAST;
                                n_state  = ST_INS;
                            end else begin
                                div_start = 1'b1;
                                div_dvd   = DEPTH_SAT;
                                n_state   = ST_DIV2;
                            end
                        end else begin
                            div_start = 1'b1;
                            div_rem   = {15'd0, i_vertex_count, 12'd0};
                            div_dsr   = i_zinv_sum;
                            n_state   = ST_DIV1;
                        end
                    end
                end
            end
            ST_DIV1: begin
                if (div_done) begin
                    n_depth = div_quo;
                    if (r_bsize == '0) begin
                        n_bucket = BKT_LAST;
                        n_state  = ST_INS;
                    end else begin
                        div_start = 1'b1;
                        div_dvd   = div_quo;
                        n_state   = ST_DIV2;
                    end
                end
            end
            ST_DIV2: begin
                if (div_done) begin
                    n_bucket = (div_quo > BKT_LAST_W) ? BKT_LAST : div_quo[BKT_W-1:0];
                    n_state  = ST_INS;
                end
            end
            ST_INS: begin
                w_ctl.insert = 1'b1;
                n_ecount     = r_ecount + 1'b1;
                n_state      = ST_IDLE;
            end
            ST_FLUSH: begin
                if (r_ecount == '0) begin
                    n_state = ST_IDLE;
                end else if (w_out_free) begin
                    w_ctl.shift  = 1'b1;
                    n_out_valid  = 1'b1;
                    n_out_handle = c_handle[0];
                    n_out_depth  = c_key[0][DEPTH_W-1:0];
                    n_out_def    = 1'b1;
                    n_out_last   = (r_ecount == CNT_W'(1));
                    n_ecount     = r_ecount - 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ecount    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ecount    <= n_ecount;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_handle     <= n_handle;
        r_depth      <= n_depth;
        r_bucket     <= n_bucket;
        r_out_handle <= n_out_handle;
        r_out_depth  <= n_out_depth;
        r_out_def    <= n_out_def;
        r_out_last   <= n_out_last;
    end

    dbs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_rem   (div_rem),
        .i_dvd   (div_dvd),
        .i_dsr   (div_dsr),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    for (genvar g = 0; g < POOL_SIZE; g++) begin : g_cell
        logic                p_gt, p_valid, x_valid;
        logic [KEY_W-1:0]    p_key, x_key;
        logic [HANDLE_W-1:0] p_handle, x_handle;

        if (g == 0) begin : g_head
            assign p_gt     = 1'b1;
            assign p_valid  = 1'b0;
            assign p_key    = '0;
            assign p_handle = '0;
        end else begin : g_mid
            assign p_gt     = c_gt[g-1];
            assign p_valid  = c_valid[g-1];
            assign p_key    = c_key[g-1];
            assign p_handle = c_handle[g-1];
        end

        if (g == POOL_SIZE - 1) begin : g_tail
            assign x_valid  = 1'b0;
            assign x_key    = '0;
            assign x_handle = '0;
        end else begin : g_body
            assign x_valid  = c_valid[g+1];
            assign x_key    = c_key[g+1];
            assign x_handle = c_handle[g+1];
        end

        dbs_cell #(.KEY_W(KEY_W)) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_new_key     ({r_bucket, r_depth}),
            .i_new_handle  (r_handle),
            .i_prev_gt     (p_gt),
            .i_prev_valid  (p_valid),
            .i_prev_key    (p_key),
            .i_prev_handle (p_handle),
            .i_next_valid  (x_valid),
            .i_next_key    (x_key),
            .i_next_handle (x_handle),
            .o_gt          (c_gt[g]),
            .o_valid       (c_valid[g]),
            .o_key         (c_key[g]),
            .o_handle      (c_handle[g])
        );
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_handle = r_out_handle;
    assign o_out_depth  = r_out_depth;
    assign o_deferred   = r_out_def;
    assign o_last       = r_out_last;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ecount <= CNT_FULL)
        else $error("entry count above pool size");

    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ecount != '0) == c_valid[0])
        else $error("chain head disagrees with entry count");

    a_pass_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_mode == MODE_INSERT && w_pass) |=>
        (r_out_valid && r_out_last && !r_out_def))
        else $error("pass-through not presented");

    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV1 || r_state == ST_DIV2))
        else $error("divider finished outside a divide state");

    a_flush_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH && r_ecount == '0) |=> (r_state == ST_IDLE && !c_valid[0]))
        else $error("flush left entries behind");

endmodule
`default_nettype wire

FILE: tb/tb_depth_bucket_sorter.sv
`default_nettype none
module tb_depth_bucket_sorter;
    import dbs_pkg::*;

    localparam int NBKT = NUM_BUCKETS_DEF;
    localparam int POOL = POOL_SIZE_DEF;
    localparam int SETTLE = 80;

    typedef struct packed {
        logic                mode;
        logic [HANDLE_W-1:0] handle;
        logic [VCNT_W-1:0]   vcnt;
        logic [SUM_W-1:0]    sum;
        logic                blend_none;
        logic                tex_alpha;
    } poly_req_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [DEPTH_W-1:0]  depth;
        logic                deferred;
        logic                last;
    } draw_t;

    typedef struct packed {
        poly_req_t           req;
        logic                typed;
        logic [HANDLE_W-1:0] pass_handle;
    } dir_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic i_mode = MODE_INSERT;
    logic [HANDLE_W-1:0] i_handle = '0;
    logic [VCNT_W-1:0] i_vertex_count = '0;
    logic [SUM_W-1:0] i_zinv_sum = '0;
    logic i_blend_none = 1'b0;
    logic i_tex_alpha = 1'b0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [HANDLE_W-1:0] o_out_handle;
    logic [DEPTH_W-1:0] o_out_depth;
    logic o_deferred;
    logic o_last;

    depth_bucket_sorter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_mode(i_mode), .i_handle(i_handle), .i_vertex_count(i_vertex_count),
        .i_zinv_sum(i_zinv_sum), .i_blend_none(i_blend_none), .i_tex_alpha(i_tex_alpha),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_out_handle(o_out_handle), .o_out_depth(o_out_depth),
        .o_deferred(o_deferred), .o_last(o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // sorter model state
    logic                cache_en_m;
    logic [BSIZE_W-1:0]  bucket_size_m;
    logic [DEPTH_W-1:0]  pool_depth [POOL];
    logic [HANDLE_W-1:0] pool_handle [POOL];
    int                  pool_bucket [POOL];
    int                  pool_fill;

    draw_t draw_q [$];
    int    errors = 0;
    bit    no_idle = 1'b0;

    function automatic logic [DEPTH_W-1:0] avg_depth(logic [VCNT_W-1:0] cnt,
                                                     logic [SUM_W-1:0] sum);
        longint unsigned q;
        if (sum == 0) return DEPTH_SAT;
        q = (longint'(cnt) << 44) / longint'(sum);
        if (q > 64'hFFFF_FFFF) return DEPTH_SAT;
        return q[DEPTH_W-1:0];
    endfunction

    function automatic int bucket_of(logic [DEPTH_W-1:0] d);
        logic [DEPTH_W-1:0] b;
        if (bucket_size_m == 0) return NBKT - 1;
        b = d / bucket_size_m;
        return (b > NBKT - 1) ? NBKT - 1 : int'(b);
    endfunction

    // farthest bucket first, then deepest, newest first among ties
    task automatic predict_req(poly_req_t r);
        bit   used [POOL];
        int   best;
        logic [44:0] key, best_key;
        draw_t o;
        if (r.mode == MODE_FLUSH) begin
            for (int i = 0; i < POOL; i++) used[i] = 1'b0;
            for (int n = 0; n < pool_fill; n++) begin
                best = -1;
                best_key = '0;
                for (int i = 0; i < pool_fill; i++) begin
                    key = {6'(pool_bucket[i]), pool_depth[i], 7'(i)};
                    if (!used[i] && (best < 0 || key > best_key)) begin
                        best = i;
                        best_key = key;
                    end
                end
                used[best] = 1'b1;
                o = '{pool_handle[best], pool_depth[best], 1'b1, n == pool_fill - 1};
                draw_q.push_back(o);
            end
            pool_fill = 0;
        end else if ((r.blend_none && !r.tex_alpha) || !cache_en_m) begin
            draw_q.push_back('{r.handle, '0, 1'b0, 1'b1});
        end else if (pool_fill < POOL) begin
            pool_depth[pool_fill] = avg_depth(r.vcnt, r.sum);
            pool_handle[pool_fill] = r.handle;
            pool_bucket[pool_fill] = bucket_of(pool_depth[pool_fill]);
            pool_fill++;
        end
    endtask

    function automatic int gap_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 19);
        if (r < 10) return 0;
        if (r < 17) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // drive one request and hold it until accepted
    task automatic send_req(poly_req_t r);
        int g;
        i_in_valid <= 1'b1;
        i_mode <= r.mode;
        i_handle <= r.handle;
        i_vertex_count <= r.vcnt;
        i_zinv_sum <= r.sum;
        i_blend_none <= r.blend_none;
        i_tex_alpha <= r.tex_alpha;
        do @(posedge i_clk); while (!o_in_ready);
        g = gap_len();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic finish_req();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        if (idx == CFG_CACHE_EN) cache_en_m = val[0];
        else bucket_size_m = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (draw_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic poly_req_t rand_req(int flush_odds);
        poly_req_t r;
        int k;
        r.mode = ($urandom_range(1, flush_odds) == 1) ? MODE_FLUSH : MODE_INSERT;
        r.handle = HANDLE_W'($urandom);
        r.vcnt = VCNT_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                     : $urandom_range(3, 16));
        k = $urandom_range(0, 9);
        if (k == 0) r.sum = '0;
        else if (k == 1) r.sum = $urandom;
        else if (k == 2) r.sum = $urandom_range(1, 255);
        else r.sum = $urandom >> $urandom_range(0, 31);
        k = $urandom_range(0, 3);
        r.blend_none = (k == 0 || k == 3);
        r.tex_alpha = (k == 1 || k == 3);
        return r;
    endfunction

    // output side: check against the oldest expectation, random stalls
    int stall = 0;
    always @(posedge i_clk) begin
        draw_t e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (draw_q.size() == 0) begin
                $display("%0t: unexpected result handle %h", $time, o_out_handle);
                errors++;
            end else begin
                e = draw_q.pop_front();
                if (o_out_handle !== e.handle || o_out_depth !== e.depth ||
                    o_deferred !== e.deferred || o_last !== e.last) begin
                    $display("%0t: expected h=%h d=%h def=%b last=%b, got h=%h d=%h def=%b last=%b",
                             $time, e.handle, e.depth, e.deferred, e.last,
                             o_out_handle, o_out_depth, o_deferred, o_last);
                    errors++;
                end
            end
        end
        if (stall > 0) begin
            stall <= stall - 1;
            i_out_ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 7) == 0) begin
            stall <= $urandom_range(0, 2);
            i_out_ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 39) == 0) begin
            stall <= $urandom_range(20, 60);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    dir_row_t dir_tbl [22];
    logic [BSIZE_W-1:0] phase_bsize [7];
    logic               phase_cache [7];

    initial begin
        poly_req_t r;
        cache_en_m = CACHE_EN_RST;
        bucket_size_m = BUCKET_SIZE_RST;
        pool_fill = 0;
        dir_tbl = '{
            '{'{MODE_INSERT, 16'h0000, 5'd3, 32'h1000_0000, 1'b1, 1'b0}, 1'b1, 16'h0000},
            '{'{MODE_INSERT, 16'hFFFF, 5'd16, 32'hFFFF_FFFF, 1'b1, 1'b0}, 1'b1, 16'hFFFF},
            '{'{MODE_FLUSH, 16'h1234, 5'd4, 32'h0, 1'b0, 1'b1}, 1'b0, 16'h0},
            '{'{MODE_INSERT, 16'h0001, 5'd3, 32'h0, 1'b0, 1'b0}, 1'b0, 16'h0},
            '{'{MODE_INSERT, 16'h0002, 5'd0, 32'h0, 1'b0, 1'b1}, 1'b0, 16'h0},
            '{'{MODE_INSERT, 16'h0003, 5'd16, 32'h1, 1'b1, 1'b1}, 1'b0, 16'h0},
            '{'{MODE_INSERT, 16'h0004, 5'd16, 32'hFFFF_FFFF, 1'b0, 1'b0}, 1'b0, 16'h0},
            '{'{MODE_INSERT, 16'h0005, 5'd31, 32'h1000_0000, 1'b0, 1'b1}, 1'b0, 16'h0},
            '{'{MODE_INSERT, 16'h0006, 5'd3, 32'h3000_0000, 1'b1, 1'b1}, 1'b0, 16'h0},
            '{'{MODE_INSERT, 16'h0007, 5'd3, 32'h3000_0000, 1'b0, 1'b0}, 1'b0, 16'h0},
            '{'{MODE_INSERT, 16'h0008, 5'd6, 32'h6000_0000, 1'b0, 1'b1}, 1'b0, 16'h0},
            '{'{MODE_INSERT, 16'h0009, 5'd4, 32'h8000_0000, 1'b0, 1'b0}, 1'b0, 16'h0},
            '{'{MODE_INSERT, 16'h000A, 5'd4, 32'h4000_0000, 1'b0, 1'b0}, 1'b0, 16'h0},
            '{'{MODE_INSERT, 16'h000B, 5'd5, 32'h4000_0000, 1'b1, 1'b1}, 1'b0, 16'h0},
            '{'{MODE_INSERT, 16'hAAAA, 5'd1, 32'h0000_0001, 1'b1, 1'b0}, 1'b1, 16'hAAAA},
            '{'{MODE_INSERT, 16'h5555, 5'd2, 32'h5555_5555, 1'b0, 1'b1}, 1'b0, 16'h0},
            '{'{MODE_INSERT, 16'hAAAA, 5'd21, 32'hAAAA_AAAA, 1'b0, 1'b0}, 1'b0, 16'h0},
            '{'{MODE_INSERT, 16'h000C, 5'd12, 32'h0FFF_FFFF, 1'b0, 1'b0}, 1'b0, 16'h0},
            '{'{MODE_FLUSH, 16'h0, 5'd0, 32'h0, 1'b1, 1'b0}, 1'b0, 16'h0},
            '{'{MODE_FLUSH, 16'hFFFF, 5'd31, 32'hFFFF_FFFF, 1'b1, 1'b1}, 1'b0, 16'h0},
            '{'{MODE_INSERT, 16'h000D, 5'd8, 32'h2000_0000, 1'b0, 1'b1}, 1'b0, 16'h0},
            '{'{MODE_FLUSH, 16'h0, 5'd0, 32'h0, 1'b0, 1'b0}, 1'b0, 16'h0}
        };
        phase_cache = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
        phase_bsize = '{32'h1, 32'hFFFF_FFFF, 32'h0, 32'h0001_0000,
                        32'h0000_8000, 32'h0008_0000, 32'h0004_0000};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tbl[i]) begin
            if (dir_tbl[i].typed)
                draw_q.push_back('{dir_tbl[i].pass_handle, '0, 1'b0, 1'b1});
            else
                predict_req(dir_tbl[i].req);
            send_req(dir_tbl[i].req);
        end
        finish_req();
        drain();

        for (int p = 0; p < 7; p++) begin
            no_idle = (p % 3 == 1);
            cfg_write(CFG_CACHE_EN, {31'b0, phase_cache[p]});
            cfg_write(CFG_BUCKET_SIZE, (p == 5) ? $urandom_range(32'h100, 32'h0010_0000)
                                                : phase_bsize[p]);
            // last phase fills the pool past capacity before flushing
            for (int n = 0; n < ((p == 6) ? 70 : 5); n++) begin
                r = rand_req((p == 6) ? 1000 : 8);
                if (p == 6) r.blend_none = 1'b0;
                predict_req(r);
                send_req(r);
            end
            r = rand_req(1);
            r.mode = MODE_FLUSH;
            predict_req(r);
            send_req(r);
            finish_req();
            drain();
        end

        if (errors == 0 && draw_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/dbs_pkg.sv
rtl/dbs_div.sv
rtl/dbs_cell.sv
rtl/depth_bucket_sorter.sv
tb/tb_depth_bucket_sorter.sv
